// ===== design/front_middle_back_queue_assert.svh =====
// assertion macros for the front/middle/back queue
// used by the top level; expects signals named clock and reset in scope
`ifndef FRONT_MIDDLE_BACK_QUEUE_ASSERT_SVH
`define FRONT_MIDDLE_BACK_QUEUE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FMBQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FMBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fmbq_pkg.sv =====
// shared types and constants for the front/middle/back queue
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package fmbq_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 7;
   localparam int GROUP   = 8;
   localparam int NGROUP  = (DEPTH + GROUP - 1) / GROUP;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_MIDDLE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP_MIDDLE  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_POP_BACK    = 3'd5;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } op_type;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic signed [WORD_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped;
      logic [STAT_W-1:0]        status;
      logic [OCC_W-1:0]         occupancy;
   } rsp_payload_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic             load;
      op_type           op;
      logic [IDX_W-1:0] pos;
      word_type         value;
   } cell_ctl_type;

endpackage

// ===== design/fmbq_cell.sv =====
// one storage cell of the queue: holds one word and shifts with its neighbours
// depends on fmbq_pkg
`timescale 1ns / 1ps

module fmbq_cell (
   input  logic                      clock,
   input  logic [fmbq_pkg::IDX_W-1:0] cell_index,
   input  fmbq_pkg::cell_ctl_type    ctl,
   input  fmbq_pkg::word_type        left_data,
   input  fmbq_pkg::word_type        right_data,
   output fmbq_pkg::word_type        data_ff,
   output fmbq_pkg::word_type        tap_ff
);

   fmbq_pkg::word_type data_in;
   fmbq_pkg::word_type tap_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         fmbq_pkg::OP_INSERT: begin
            // cells behind the gap take their front neighbour
            if (cell_index > ctl.pos) begin
               data_in = left_data;
            end else if (cell_index == ctl.pos) begin
               data_in = ctl.value;
            end
         end
         fmbq_pkg::OP_REMOVE: begin
            if (cell_index >= ctl.pos) begin
               data_in = right_data;
            end
         end
         default: begin
         end
      endcase
   end

   // only the cell being removed drives its word onto the reduction tree
   assign tap_in = (ctl.op == fmbq_pkg::OP_REMOVE && cell_index == ctl.pos)
                   ? data_ff : '0;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctl.load) begin
         tap_ff <= tap_in;
      end
   end

endmodule

// ===== design/fmbq_group.sv =====
// registered or-reduction of one group of cell taps
// depends on fmbq_pkg
`timescale 1ns / 1ps

module fmbq_group (
   input  logic                                       clock,
   input  logic                                       enable,
   input  logic [fmbq_pkg::GROUP-1:0][fmbq_pkg::WORD_W-1:0] taps,
   output fmbq_pkg::word_type                         group_ff
);

   fmbq_pkg::word_type group_in;

   always_comb begin
      group_in = '0;
      for (int k = 0; k < fmbq_pkg::GROUP; k++) begin
         group_in = group_in | taps[k];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         group_ff <= group_in;
      end
   end

endmodule

// ===== design/front_middle_back_queue.sv =====
// front/middle/back queue: a row of shifting cells with a pipelined read-out tree
// depends on fmbq_pkg, fmbq_cell, fmbq_group and front_middle_back_queue_assert.svh
//
// Usage: commands enter on req_valid/req_ready with req_payload (command, value).
// Push front/middle/back inserts value at position 0, floor(n/2) or n; pop
// front/middle/back removes position 0, floor((n-1)/2) or n-1, n being the
// occupancy before the command. Every item gives exactly one response on
// rsp_valid/rsp_ready with rsp_payload (popped, status, occupancy).
// The cell row updates at the edge that accepts the item, so the next item may
// follow in the very next cycle: one item per cycle sustained while the receiver takes responses.
// rsp_valid rises once the item has passed the read-out stages: the removed word goes from
// the cell tap registers into registered or-reductions of 8-cell groups, then
// an or across the groups feeds the response register.
// A stalled receiver holds the response register; the tap and group stages
// take two more items, after which req_ready drops.
// Reset (synchronous, active high) empties the queue and the pipeline; the
// cell contents are not cleared and are never read before being written.
`timescale 1ns / 1ps
`include "front_middle_back_queue_assert.svh"

module front_middle_back_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  fmbq_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output fmbq_pkg::rsp_payload_type rsp_payload
);

   localparam int PAD = fmbq_pkg::NGROUP * fmbq_pkg::GROUP;

   logic [fmbq_pkg::CNT_W-1:0] count_ff, count_in;
   fmbq_pkg::cell_ctl_type     ctl;
   fmbq_pkg::word_type         cell_data [fmbq_pkg::DEPTH];
   logic [PAD-1:0][fmbq_pkg::WORD_W-1:0] tap_pad;
   fmbq_pkg::word_type         group_word [fmbq_pkg::NGROUP];

   logic accept, is_push, is_pop, full, empty;
   logic [fmbq_pkg::STAT_W-1:0] status_in;
   logic s1_adv, s2_adv, s2_free, out_free;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_take_ff;
   logic [fmbq_pkg::STAT_W-1:0] s1_status_ff;
   logic [fmbq_pkg::OCC_W-1:0]  s1_occ_ff;
   logic                        s2_valid_ff, s2_valid_in;
   logic                        s2_take_ff;
   logic [fmbq_pkg::STAT_W-1:0] s2_status_ff;
   logic [fmbq_pkg::OCC_W-1:0]  s2_occ_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   fmbq_pkg::rsp_payload_type   rsp_payload_ff;
   fmbq_pkg::word_type          reduce_word;

   // ---------------- command decode ----------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s2_adv    = s2_valid_ff && out_free;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign accept    = req_valid && req_ready;

   assign is_push = req_payload.command <= fmbq_pkg::CMD_PUSH_BACK;
   assign is_pop  = req_payload.command >= fmbq_pkg::CMD_POP_FRONT &&
                    req_payload.command <= fmbq_pkg::CMD_POP_BACK;
   assign full    = count_ff == fmbq_pkg::CNT_W'(fmbq_pkg::DEPTH);
   assign empty   = count_ff == '0;

   always_comb begin
      ctl.load  = accept;
      ctl.value = req_payload.value;
      ctl.op    = fmbq_pkg::OP_HOLD;
      ctl.pos   = '0;
      status_in = fmbq_pkg::ST_DONE;
      count_in  = count_ff;
      if (is_push) begin
         if (full) begin
            status_in = fmbq_pkg::ST_FULL;
         end else begin
            ctl.op   = accept ? fmbq_pkg::OP_INSERT : fmbq_pkg::OP_HOLD;
            count_in = count_ff + 1'b1;
         end
      end else if (is_pop) begin
         if (empty) begin
            status_in = fmbq_pkg::ST_EMPTY;
         end else begin
            ctl.op   = accept ? fmbq_pkg::OP_REMOVE : fmbq_pkg::OP_HOLD;
            count_in = count_ff - 1'b1;
         end
      end
      case (req_payload.command)
         fmbq_pkg::CMD_PUSH_MIDDLE: ctl.pos = fmbq_pkg::IDX_W'(count_ff >> 1);
         fmbq_pkg::CMD_PUSH_BACK:   ctl.pos = fmbq_pkg::IDX_W'(count_ff);
         fmbq_pkg::CMD_POP_MIDDLE:  ctl.pos = fmbq_pkg::IDX_W'((count_ff - 1'b1) >> 1);
         fmbq_pkg::CMD_POP_BACK:    ctl.pos = fmbq_pkg::IDX_W'(count_ff - 1'b1);
         default:                   ctl.pos = '0;
      endcase
   end

   // ---------------- cell row ----------------
   for (genvar i = 0; i < fmbq_pkg::DEPTH; i++) begin : g_cell
      fmbq_pkg::word_type left_data, right_data, tap_word;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_l
         assign left_data = cell_data[i-1];
      end
      if (i == fmbq_pkg::DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_r
         assign right_data = cell_data[i+1];
      end

      fmbq_cell u_cell (
         .clock      (clock),
         .cell_index (fmbq_pkg::IDX_W'(i)),
         .ctl        (ctl),
         .left_data  (left_data),
         .right_data (right_data),
         .data_ff    (cell_data[i]),
         .tap_ff     (tap_word)
      );
      assign tap_pad[i] = tap_word;
   end

   for (genvar j = fmbq_pkg::DEPTH; j < PAD; j++) begin : g_pad
      assign tap_pad[j] = '0;
   end

   // ---------------- read-out tree ----------------
   for (genvar g = 0; g < fmbq_pkg::NGROUP; g++) begin : g_group
      fmbq_group u_group (
         .clock    (clock),
         .enable   (s1_adv),
         .taps     (tap_pad[g*fmbq_pkg::GROUP +: fmbq_pkg::GROUP]),
         .group_ff (group_word[g])
      );
   end

   always_comb begin
      reduce_word = '0;
      for (int g = 0; g < fmbq_pkg::NGROUP; g++) begin
         reduce_word = reduce_word | group_word[g];
      end
   end

   // ---------------- pipeline control ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_take_ff   <= ctl.op == fmbq_pkg::OP_REMOVE;
         s1_status_ff <= status_in;
         s1_occ_ff    <= fmbq_pkg::OCC_W'(count_in);
      end
      if (s1_adv) begin
         s2_take_ff   <= s1_take_ff;
         s2_status_ff <= s1_status_ff;
         s2_occ_ff    <= s1_occ_ff;
      end
      if (s2_adv) begin
         rsp_payload_ff.popped    <= s2_take_ff ? reduce_word : '1;
         rsp_payload_ff.status    <= s2_status_ff;
         rsp_payload_ff.occupancy <= s2_occ_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------- assertions ----------------
   `FMBQ_ASSERT_SAME(a_count_bound, 1'b1,
      count_ff <= fmbq_pkg::CNT_W'(fmbq_pkg::DEPTH), "occupancy above depth")
   `FMBQ_ASSERT_NEXT(a_count_hold, !accept, $stable(count_ff),
      "occupancy changed without an item")
   `FMBQ_ASSERT_NEXT(a_full_drop, accept && is_push && full, $stable(count_ff),
      "push on full store changed occupancy")
   `FMBQ_ASSERT_SAME(a_empty_word, rsp_valid_ff && rsp_payload_ff.status == fmbq_pkg::ST_EMPTY,
      rsp_payload_ff.popped == '1, "pop on empty did not return all ones")
   `FMBQ_ASSERT_NEXT(a_s2_hold, s2_valid_ff && !out_free, s2_valid_ff,
      "read-out stage lost an item under stall")

endmodule
